### src/cab_pkg.sv
// cab_pkg: shared types, constants and helpers for the cursor alpha blender
// no dependencies; used by cursor_alpha_blend by scoped names
`default_nettype none

package cab_pkg;

  // image and register geometry
  localparam int unsigned MaxImageDim = 8192;
  localparam int unsigned DimW        = 14;
  localparam int unsigned CoordW      = 13;
  localparam int unsigned AddrW       = 5;

  // saturated image dimension as a dim-wide value
  localparam logic [DimW-1:0] MaxDim = DimW'(MaxImageDim);

  // register map, index of the register in the map
  typedef enum logic [2:0] {
    REG_LAYOUT = 3'd0,
    REG_LEFT_X = 3'd1,
    REG_TOP_Y  = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4
  } reg_idx_e;

  // supported byte orders of the destination word
  typedef enum logic [2:0] {
    LAYOUT_24_R2G1B0 = 3'd0,
    LAYOUT_24_R0G1B2 = 3'd1,
    LAYOUT_32_R2G1B0 = 3'd2,
    LAYOUT_32_R0G1B2 = 3'd3,
    LAYOUT_32_R3G2B1 = 3'd4,
    LAYOUT_32_R1G2B3 = 3'd5
  } pixel_layout_e;

  localparam logic [2:0] LayoutReset = LAYOUT_32_R2G1B0;

  // byte positions of r, g and b for one layout
  typedef struct packed {
    logic [1:0] rpos;
    logic [1:0] gpos;
    logic [1:0] bpos;
  } chan_pos_t;

  function automatic chan_pos_t layout_pos(input logic [2:0] layout);
    chan_pos_t p;
    case (layout)
      LAYOUT_24_R2G1B0: p = '{rpos: 2'd2, gpos: 2'd1, bpos: 2'd0};
      LAYOUT_24_R0G1B2: p = '{rpos: 2'd0, gpos: 2'd1, bpos: 2'd2};
      LAYOUT_32_R2G1B0: p = '{rpos: 2'd2, gpos: 2'd1, bpos: 2'd0};
      LAYOUT_32_R0G1B2: p = '{rpos: 2'd0, gpos: 2'd1, bpos: 2'd2};
      LAYOUT_32_R3G2B1: p = '{rpos: 2'd3, gpos: 2'd2, bpos: 2'd1};
      LAYOUT_32_R1G2B3: p = '{rpos: 2'd1, gpos: 2'd2, bpos: 2'd3};
      default:          p = '{rpos: 2'd2, gpos: 2'd1, bpos: 2'd0};
    endcase
    return p;
  endfunction

  function automatic logic layout_ok(input logic [2:0] layout);
    logic ok;
    case (layout)
      LAYOUT_24_R2G1B0, LAYOUT_24_R0G1B2, LAYOUT_32_R2G1B0,
      LAYOUT_32_R0G1B2, LAYOUT_32_R3G2B1, LAYOUT_32_R1G2B3: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // one channel: (d*(255-a)+127)/255 + s, modulo 256
  // the divide by 255 is (t + 1 + (t >> 8)) >> 8, exact for t below 65535
  function automatic logic [7:0] blend_chan(input logic [7:0] d,
                                            input logic [7:0] s,
                                            input logic [7:0] a);
    logic [15:0] t;
    logic [16:0] u;
    logic [7:0]  q;
    t = {8'd0, d} * {8'd0, 8'd255 - a} + 16'd127;
    u = {1'b0, t} + 17'd1 + {9'd0, t[15:8]};
    q = u[15:8];
    return q + s;
  endfunction

endpackage

`default_nettype wire

### src/cursor_alpha_blend.sv
// cursor_alpha_blend: places one premultiplied cursor pixel on the image,
// clips it and blends it over the framebuffer pixel below; needs cab_pkg
//
// usage
//   input stream beats carry one cursor pixel with its cursor column and
//   row and the destination pixel it lands on; every beat gives exactly one
//   output beat with the blended pixel, its image column and row, and the
//   visible flag in tuser (write the pixel back only when it is set).
//   an invisible pixel comes back unchanged with zero coordinates.
//   the apb port holds layout, cursor origin and image size; write it only
//   while no beat is in flight. pready is tied high, reads return values.
// timing
//   two register stages: input register, then blend logic, then the output
//   register. an accepted input beat moves from the input register into the
//   output register, where it becomes valid; one beat is taken every
//   cycle unless the output stalls, the rate is set by the single blend stage,
//   one 8x8 multiply and a constant divide per channel.
// reset and stall
//   rst_ni clears both stage valid flags and loads the register defaults
//   (layout 2, origin 0,0, image 1920x1080). when m_axis_tready_i is low
//   the output beat holds; an empty input register still takes one more
//   beat and then s_axis_tready_o drops until the output moves on.
`default_nettype none

module cursor_alpha_blend (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // apb configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cab_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // input stream
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // tdata: cursor_argb[31:0], cursor_col[39:32], cursor_line[47:40],
  //        dest_pixel[79:48]
  input  logic [79:0]               s_axis_tdata_i,
  // output stream
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // tdata: blended_pixel[31:0], dest_x[44:32], dest_y[57:45], zeros above
  output logic [63:0]               m_axis_tdata_o,
  // tuser: visible[0]
  output logic                      m_axis_tuser_o
);

  localparam int unsigned DimW   = cab_pkg::DimW;
  localparam int unsigned CoordW = cab_pkg::CoordW;

  // configuration registers
  logic [2:0]      layout_q;
  logic [DimW-1:0] left_x_q, top_y_q, width_q, height_q;
  logic [2:0]      cfg_idx;
  logic            cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q <= cab_pkg::LayoutReset;
      left_x_q <= '0;
      top_y_q  <= '0;
      width_q  <= DimW'(1920);
      height_q <= DimW'(1080);
    end else if (cfg_wr) begin
      case (cfg_idx)
        cab_pkg::REG_LAYOUT: layout_q <= pwdata[2:0];
        cab_pkg::REG_LEFT_X: left_x_q <= pwdata[DimW-1:0];
        cab_pkg::REG_TOP_Y:  top_y_q  <= pwdata[DimW-1:0];
        cab_pkg::REG_WIDTH:  width_q  <= pwdata[DimW-1:0];
        cab_pkg::REG_HEIGHT: height_q <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      cab_pkg::REG_LAYOUT: prdata = {29'd0, layout_q};
      cab_pkg::REG_LEFT_X: prdata = {{(32-DimW){1'b0}}, left_x_q};
      cab_pkg::REG_TOP_Y:  prdata = {{(32-DimW){1'b0}}, top_y_q};
      cab_pkg::REG_WIDTH:  prdata = {{(32-DimW){1'b0}}, width_q};
      cab_pkg::REG_HEIGHT: prdata = {{(32-DimW){1'b0}}, height_q};
      default:             prdata = '0;
    endcase
  end

  // pipeline handshake
  logic in_vld_q, out_vld_q;
  logic out_adv, in_adv;

  assign out_adv         = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_vld_q || out_adv;
  assign in_adv          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_vld_q  <= s_axis_tvalid_i;
      if (out_adv)         out_vld_q <= in_vld_q;
    end
  end

  // input register, payload only
  logic [31:0] argb_q, dst_q;
  logic [7:0]  col_q, row_q;

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      argb_q <= s_axis_tdata_i[31:0];
      col_q  <= s_axis_tdata_i[39:32];
      row_q  <= s_axis_tdata_i[47:40];
      dst_q  <= s_axis_tdata_i[79:48];
    end
  end

  // placement and clipping
  logic signed [DimW:0] x, y;
  logic [DimW-1:0]      w, h;
  logic                 vis;

  always_comb begin
    x   = $signed({left_x_q[DimW-1], left_x_q}) + $signed({7'd0, col_q});
    y   = $signed({top_y_q[DimW-1], top_y_q}) + $signed({7'd0, row_q});
    w   = (width_q > cab_pkg::MaxDim) ? cab_pkg::MaxDim : width_q;
    h   = (height_q > cab_pkg::MaxDim) ? cab_pkg::MaxDim : height_q;
    vis = cab_pkg::layout_ok(layout_q)
          && !x[DimW] && (x[DimW-1:0] < w)
          && !y[DimW] && (y[DimW-1:0] < h);
  end

  // per channel blend, then place the bytes by layout
  cab_pkg::chan_pos_t pos;
  logic [7:0]         dr, dg, db, br, bg, bb;
  logic [31:0]        pix;

  always_comb begin
    pos = cab_pkg::layout_pos(layout_q);
    dr  = dst_q[8*pos.rpos +: 8];
    dg  = dst_q[8*pos.gpos +: 8];
    db  = dst_q[8*pos.bpos +: 8];
    br  = cab_pkg::blend_chan(dr, argb_q[23:16], argb_q[31:24]);
    bg  = cab_pkg::blend_chan(dg, argb_q[15:8], argb_q[31:24]);
    bb  = cab_pkg::blend_chan(db, argb_q[7:0], argb_q[31:24]);
    pix = dst_q;
    if (vis) begin
      pix[8*pos.rpos +: 8] = br;
      pix[8*pos.gpos +: 8] = bg;
      pix[8*pos.bpos +: 8] = bb;
    end
  end

  // output register
  logic [31:0]       pix_q;
  logic [CoordW-1:0] dx_q, dy_q;
  logic              vis_q;

  always_ff @(posedge clk_i) begin
    if (out_adv && in_vld_q) begin
      pix_q <= pix;
      vis_q <= vis;
      dx_q  <= vis ? x[CoordW-1:0] : '0;
      dy_q  <= vis ? y[CoordW-1:0] : '0;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'd0, dy_q, dx_q, pix_q};
  assign m_axis_tuser_o  = vis_q;

endmodule

`default_nettype wire
